>>> rtl/core/rost_pkg.sv
// ----------------------------------------------------------------------------
// rost_pkg
// Shared constants and codes for the range OR segment tree block.
// ----------------------------------------------------------------------------
`default_nettype none

package rost_pkg;

    // Default sizing, handed down as top-level parameter defaults
    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int VALUE_WIDTH_DEF  = 32;

    // Element count after reset, before saturation to the tree size
    localparam int RESET_COUNT = 1024;

    // Fixed widths of the stream and configuration fields
    localparam int POS_W    = 10;
    localparam int DATA_W   = 32;
    localparam int BOUND_W  = 11;
    localparam int CFG_W    = 11;
    localparam int S_DATA_W = POS_W + DATA_W + 2 * BOUND_W;

    // Item kinds carried on s_tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

endpackage

`default_nettype wire

>>> rtl/core/range_or_segment_tree.sv
// Write: stores the leaf, then each ancestor up to the root; a write outside the
//   tree is accepted and dropped. Query: per tree level, a left-bound step (ST_QLO)
//   then a right-bound step (ST_QHI); s_tready stays low until the walk ends, and a
//   held result stalls the walk. Reset: synchronous, active low, then a clearing
//   pass zeroes the tree RAM with s_tready low.
// ----------------------------------------------------------------------------
// range_or_segment_tree
// Bottom-up segment tree combining values by bitwise OR: point writes and
// half-open range OR queries over a single tree RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module range_or_segment_tree
    import rost_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Input stream
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // tdata, from bit 0: position[9:0], new_value[41:10],
    // range_start[52:42], range_end[63:53]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // tuser: op[0]
    input  wire logic                s_tuser,
    // Result stream
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // tdata, from bit 0: or_result[31:0]
    output logic      [DATA_W-1:0]   m_tdata,
    // Configuration: element_count
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CFG_W-1:0]    cfg_data
);

    localparam int DEPTH    = 2 * MAX_ELEMENTS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(MAX_ELEMENTS + 1);
    localparam int NODE_W   = CNT_W + 1;
    localparam int CMP_W    = (CNT_W > BOUND_W) ? CNT_W : BOUND_W;
    localparam int RST_CNT  = (RESET_COUNT > MAX_ELEMENTS) ? MAX_ELEMENTS : RESET_COUNT;
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);
    localparam logic [CMP_W-1:0]  MAX_CMP  = CMP_W'(MAX_ELEMENTS);
    localparam logic [NODE_W-1:0] ROOT     = NODE_W'(1);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_WUP   = 5'b00100,
        ST_QLO   = 5'b01000,
        ST_QHI   = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    // lo doubles as the current node on the write path
    logic [NODE_W-1:0]    lo_reg, lo_next;
    logic [NODE_W-1:0]    hi_reg, hi_next;
    // acc doubles as the current node value on the write path
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]    out_data_reg, out_data_next;

    // RAM port signals
    logic                   ram_we, ram_re;
    logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

    // Unpacked input fields
    logic                 in_op;
    logic [POS_W-1:0]     in_pos;
    logic [DATA_W-1:0]    in_value;
    logic [BOUND_W-1:0]   in_start, in_end;

    logic [63:0]            value_ext;
    logic [VALUE_WIDTH-1:0] in_value_w;
    logic [VALUE_WIDTH+DATA_W-1:0] acc_ext;
    logic [CMP_W-1:0]     count_cmp, start_cmp, end_cmp, pos_cmp, cfg_cmp;
    logic [CNT_W-1:0]     start_sat, end_sat, cfg_sat;
    logic                 pos_ok;
    logic [NODE_W-1:0]    leaf_node, parent_node, lo_start, hi_end, hi_dec;
    logic [VALUE_WIDTH-1:0] up_value;

    assign in_op    = s_tuser;
    assign in_pos   = s_tdata[POS_W-1:0];
    assign in_value = s_tdata[POS_W+DATA_W-1:POS_W];
    assign in_start = s_tdata[POS_W+DATA_W+BOUND_W-1:POS_W+DATA_W];
    assign in_end   = s_tdata[S_DATA_W-1:POS_W+DATA_W+BOUND_W];

    // Fit the value to the stored width
    assign value_ext  = {32'b0, in_value};
    assign in_value_w = value_ext[VALUE_WIDTH-1:0];

    // Saturate the query bounds and check the write position
    assign count_cmp = CMP_W'(count_reg);
    assign start_cmp = CMP_W'(in_start);
    assign end_cmp   = CMP_W'(in_end);
    assign pos_cmp   = CMP_W'(in_pos);
    assign start_sat = (start_cmp > count_cmp) ? count_reg : start_cmp[CNT_W-1:0];
    assign end_sat   = (end_cmp > count_cmp) ? count_reg : end_cmp[CNT_W-1:0];
    assign pos_ok    = pos_cmp < count_cmp;

    // Tree node arithmetic
    assign leaf_node   = NODE_W'(count_reg) + NODE_W'(in_pos);
    assign lo_start    = NODE_W'(count_reg) + NODE_W'(start_sat);
    assign hi_end      = NODE_W'(count_reg) + NODE_W'(end_sat);
    assign parent_node = lo_reg >> 1;
    assign up_value    = acc_reg | ram_rdata;
    assign hi_dec      = hi_reg - ROOT;

    // Saturate a written element count into 1..MAX_ELEMENTS
    assign cfg_cmp = CMP_W'(cfg_data);
    always_comb begin
        priority if (cfg_cmp == '0) begin
            cfg_sat = CNT_W'(1);
        end else if (cfg_cmp > MAX_CMP) begin
            cfg_sat = MAX_CMP[CNT_W-1:0];
        end else begin
            cfg_sat = cfg_cmp[CNT_W-1:0];
        end
    end

    assign cfg_ready  = 1'b1;
    assign count_next = (cfg_valid && cfg_ready) ? cfg_sat : count_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Main sequencer: clear pass, leaf-to-root update, bound walk for queries
    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        rd_pend_next   = 1'b0;
        acc_next       = acc_reg | (rd_pend_reg ? ram_rdata : '0);
        acc_ext        = {{DATA_W{1'b0}}, acc_next};
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_op == OP_WRITE) begin
                        // Store the leaf and fetch its sibling
                        if (pos_ok) begin
                            ram_we    = 1'b1;
                            ram_waddr = leaf_node[ADDR_W-1:0];
                            ram_wdata = in_value_w;
                            acc_next  = in_value_w;
                            lo_next   = leaf_node;
                            if (leaf_node > ROOT) begin
                                ram_re     = 1'b1;
                                ram_raddr  = leaf_node[ADDR_W-1:0] ^ ADDR_W'(1);
                                state_next = ST_WUP;
                            end
                        end
                    end else begin
                        lo_next    = lo_start;
                        hi_next    = hi_end;
                        acc_next   = '0;
                        state_next = ST_QLO;
                    end
                end
            end
            ST_WUP: begin
                // Combine with the sibling, write the parent, fetch the next sibling
                ram_we    = 1'b1;
                ram_waddr = parent_node[ADDR_W-1:0];
                ram_wdata = up_value;
                acc_next  = up_value;
                lo_next   = parent_node;
                if (parent_node > ROOT) begin
                    ram_re    = 1'b1;
                    ram_raddr = parent_node[ADDR_W-1:0] ^ ADDR_W'(1);
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_QLO: begin
                if (lo_reg < hi_reg) begin
                    // Left bound: take an odd node and step past it
                    if (lo_reg[0]) begin
                        ram_re       = 1'b1;
                        ram_raddr    = lo_reg[ADDR_W-1:0];
                        rd_pend_next = 1'b1;
                        lo_next      = lo_reg + ROOT;
                    end
                    state_next = ST_QHI;
                end else if (!out_valid_reg || m_tready) begin
                    // Bounds met: hand the result to the output register
                    out_valid_next = 1'b1;
                    out_data_next  = acc_ext[DATA_W-1:0];
                    state_next     = ST_IDLE;
                end
            end
            ST_QHI: begin
                // Right bound: step below an odd node and take it, then go up a level
                if (hi_reg[0]) begin
                    ram_re       = 1'b1;
                    ram_raddr    = hi_dec[ADDR_W-1:0];
                    rd_pend_next = 1'b1;
                    hi_next      = hi_dec >> 1;
                end else begin
                    hi_next = hi_reg >> 1;
                end
                lo_next    = lo_reg >> 1;
                state_next = ST_QLO;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            count_reg     <= CNT_W'(RST_CNT);
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    rost_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_tree_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The sibling or bound read never collides with the node being written
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("tree RAM read and write hit the same entry");

    // A pending read is only ever folded in during a query walk
    a_pend_in_query: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (state_reg == ST_QLO || state_reg == ST_QHI))
        else $error("read pending outside a query");

    // A result appears only when a query walk has finished
    a_result_from_query: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_QLO))
        else $error("result raised outside a query");

    // Element count always stays within the tree size
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) && (CMP_W'(count_reg) <= MAX_CMP))
        else $error("element count out of range");

    // No transaction is taken while the clearing pass runs
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input taken during clearing pass");

endmodule

`default_nettype wire

>>> rtl/core/rost_ram.sv
// ----------------------------------------------------------------------------
// rost_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rost_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
